// ===== hdl/pbfl_pkg.sv =====
// ----------------------------------------------------------------------------
// pbfl_pkg
// Shared sizes and types for the per-bin free list queues.
// ----------------------------------------------------------------------------
package pbfl_pkg;

    localparam int BINS     = 128;
    localparam int CHUNKS   = 1024;

    localparam int BIN_W    = 7;
    localparam int CHUNK_W  = 10;
    localparam int BIN_AW   = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int CHUNK_AW = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int LINK_W   = $clog2(CHUNKS + 1);

    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(CHUNKS);

    typedef logic [LINK_W-1:0] link_t;

    typedef enum logic {
        CMD_STORE = 1'b0,
        CMD_POP   = 1'b1
    } cmd_t;

    typedef struct packed {
        link_t head;
        link_t tail;
    } bin_entry_t;

    typedef struct packed {
        logic              we;
        logic [BIN_AW-1:0] waddr;
        bin_entry_t        wdata;
    } bin_wr_t;

    typedef struct packed {
        logic                we;
        logic [CHUNK_AW-1:0] waddr;
        link_t               wdata;
    } link_wr_t;

endpackage

// ===== hdl/pbfl_bin_mem.sv =====
// ----------------------------------------------------------------------------
// pbfl_bin_mem
// Head/tail pointer memory, one entry per bin, registered read.
// Entries never written since reset read as empty (none/none).
// ----------------------------------------------------------------------------
module pbfl_bin_mem
    import pbfl_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [BIN_AW-1:0] raddr,
    output bin_entry_t        rdata,
    input  bin_wr_t           wr
);

    bin_entry_t mem [BINS];
    logic [BINS-1:0] vld_reg;
    bin_entry_t rdata_reg;
    logic rvld_reg;

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.waddr] <= wr.wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end else begin
            if (wr.we) begin
                vld_reg[wr.waddr] <= 1'b1;
            end
            rvld_reg <= vld_reg[raddr];
        end
    end

    assign rdata = rvld_reg ? rdata_reg : '{head: LINK_NONE, tail: LINK_NONE};

endmodule

// ===== hdl/pbfl_link_mem.sv =====
// ----------------------------------------------------------------------------
// pbfl_link_mem
// Downward link per chunk (next chunk toward the tail), registered read.
// ----------------------------------------------------------------------------
module pbfl_link_mem
    import pbfl_pkg::*;
(
    input  logic                aclk,
    input  logic [CHUNK_AW-1:0] raddr,
    output link_t               rdata,
    input  link_wr_t            wr
);

    link_t mem [CHUNKS];
    link_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.waddr] <= wr.wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/per_bin_free_list_queues_core.sv =====
// ----------------------------------------------------------------------------
// per_bin_free_list_queues_core
// One FIFO of free chunk indices per size bin, kept as linked lists in memory.
// ----------------------------------------------------------------------------
// Store (tuser 0) appends a chunk at the tail of a bin and gives no result;
// pop (tuser 1) removes the head of a bin and gives one result item, with
// tuser set and data zero when the bin was empty. One item is in work at a
// time: an item passes the bin state (store to an empty bin, pop of an empty
// bin) or the bin and then the link state (store behind an existing tail, pop
// of a listed chunk), for the registered reads of the bin pointer memory and
// then the link memory, each read-modify-written through a single write port.
// A pop that is done waits while the previous result is still held on the
// master side. No clearing pass after reset: bin pointers carry valid bits.
// ----------------------------------------------------------------------------
module per_bin_free_list_queues_core
    import pbfl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // size_bin[6:0], chunk_index[16:7], zero pad
    input  logic        s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // popped_chunk[9:0], zero pad
    output logic        m_tuser    // bin_was_empty
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BIN,
        ST_LINK
    } state_t;

    state_t              state_reg;
    cmd_t                cmd_reg;
    logic [BIN_W-1:0]    bin_reg;
    logic [CHUNK_W-1:0]  chunk_reg;
    link_t               head_reg;
    link_t               tail_reg;
    logic                m_tvalid_reg;
    logic [CHUNK_W-1:0]  popped_reg;
    logic                empty_reg;

    logic [BIN_AW-1:0]   bin_raddr;
    bin_entry_t          bin_rd;
    bin_wr_t             bin_wr;
    logic [CHUNK_AW-1:0] link_raddr;
    link_t               link_rd;
    link_wr_t            link_wr;

    logic                bin_ok;
    logic                chunk_ok;
    logic                head_live;
    logic                tail_live;
    logic                next_live;
    logic                out_free;
    logic                s_accept;
    logic                res_load;

    assign s_accept  = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign out_free  = !m_tvalid_reg || m_tready;

    assign bin_ok    = 32'(bin_reg) < BINS;
    assign chunk_ok  = 32'(chunk_reg) < CHUNKS;
    assign head_live = 32'(bin_rd.head) < CHUNKS;
    assign tail_live = 32'(bin_rd.tail) < CHUNKS;
    assign next_live = 32'(link_rd) < CHUNKS;

    // a pop result is loaded this cycle
    assign res_load  = (cmd_reg == CMD_POP) && out_free &&
                       ((state_reg == ST_LINK) ||
                        (state_reg == ST_BIN && !(bin_ok && head_live)));

    assign bin_raddr  = (state_reg == ST_IDLE) ? BIN_AW'(s_tdata[BIN_W-1:0])
                                               : BIN_AW'(bin_reg);
    assign link_raddr = (state_reg == ST_BIN) ? CHUNK_AW'(bin_rd.head)
                                              : CHUNK_AW'(head_reg);

    pbfl_bin_mem u_bin_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .raddr   (bin_raddr),
        .rdata   (bin_rd),
        .wr      (bin_wr)
    );

    pbfl_link_mem u_link_mem (
        .aclk  (aclk),
        .raddr (link_raddr),
        .rdata (link_rd),
        .wr    (link_wr)
    );

    always_comb begin
        bin_wr       = '0;
        bin_wr.waddr = BIN_AW'(bin_reg);
        link_wr      = '0;
        unique case (state_reg)
            ST_BIN: begin
                if (cmd_reg == CMD_STORE && bin_ok && chunk_ok) begin
                    link_wr.we        = 1'b1;
                    link_wr.waddr     = CHUNK_AW'(chunk_reg);
                    link_wr.wdata     = LINK_NONE;
                    bin_wr.we         = 1'b1;
                    bin_wr.wdata.head = tail_live ? bin_rd.head : LINK_W'(chunk_reg);
                    bin_wr.wdata.tail = LINK_W'(chunk_reg);
                end
            end
            ST_LINK: begin
                if (cmd_reg == CMD_STORE) begin
                    link_wr.we    = 1'b1;
                    link_wr.waddr = CHUNK_AW'(tail_reg);
                    link_wr.wdata = LINK_W'(chunk_reg);
                end else if (out_free) begin
                    bin_wr.we = 1'b1;
                    if (next_live) begin
                        bin_wr.wdata.head = link_rd;
                        bin_wr.wdata.tail = tail_reg;
                    end else begin
                        bin_wr.wdata.head = LINK_NONE;
                        bin_wr.wdata.tail = LINK_NONE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (res_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        cmd_reg   <= cmd_t'(s_tuser);
                        bin_reg   <= s_tdata[BIN_W-1:0];
                        chunk_reg <= s_tdata[BIN_W+CHUNK_W-1:BIN_W];
                        state_reg <= ST_BIN;
                    end
                end
                ST_BIN: begin
                    head_reg <= bin_rd.head;
                    tail_reg <= bin_rd.tail;
                    if (cmd_reg == CMD_STORE) begin
                        state_reg <= (bin_ok && chunk_ok && tail_live) ? ST_LINK : ST_IDLE;
                    end else if (bin_ok && head_live) begin
                        state_reg <= ST_LINK;
                    end else if (out_free) begin
                        popped_reg   <= '0;
                        empty_reg    <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                ST_LINK: begin
                    if (cmd_reg == CMD_STORE) begin
                        state_reg <= ST_IDLE;
                    end else if (out_free) begin
                        popped_reg   <= CHUNK_W'(head_reg);
                        empty_reg    <= 1'b0;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = 16'(popped_reg);
    assign m_tuser  = empty_reg;

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("empty pop result carries a chunk");

    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("second item taken while one is in work");

    a_store_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE && cmd_reg == CMD_STORE && !m_tvalid |=> !m_tvalid)
        else $error("store produced a result");

    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !link_wr.we && !bin_wr.we)
        else $error("memory write while idle");

endmodule
